FILE: design/dft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dft_pkg: shared constants and types of the delay flag timer table
// Slot count, command and status codes, sequencer states, step and write
// records passed between the table, the slot unit and the sequencer.
// ----------------------------------------------------------------------------
package dft_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [7:0] FREE_TYPE = 8'h00;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_REGISTERED = 2'd1;
	localparam logic [1:0] ST_FULL       = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} dft_state_t;

	typedef struct packed {
		logic              done;
		logic              wr_en;
		logic [7:0]        wr_type;
		logic [15:0]       wr_count;
		logic [1:0]        status;
		logic              at_slot;
		logic [15:0]       remaining;
	} dft_step_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [7:0]        typ;
		logic [15:0]       cnt;
	} dft_wr_t;

endpackage
`default_nettype wire

FILE: design/dft_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dft_table: slot storage
// Holds the flag type and remaining count of every slot; one read and one
// write at the slot under scan. Reset frees every slot.
// ----------------------------------------------------------------------------
module dft_table (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [dft_pkg::IDX_W-1:0] rd_idx,
	output logic      [7:0]               rd_type,
	output logic      [15:0]              rd_count,
	input  wire dft_pkg::dft_wr_t         wr
);
	import dft_pkg::*;

	logic [7:0]  type_q  [SLOTS];
	logic [15:0] count_q [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				type_q[i]  <= FREE_TYPE;
				count_q[i] <= 16'd0;
			end
		end else if (wr.en) begin
			type_q[wr.idx]  <= wr.typ;
			count_q[wr.idx] <= wr.cnt;
		end
	end

	assign rd_type  = type_q[rd_idx];
	assign rd_count = count_q[rd_idx];

endmodule
`default_nettype wire

FILE: design/dft_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dft_unit: shared slot unit
// Compares one slot against the request, decrements through a single
// subtractor and decides the slot update and whether the scan ends.
// ----------------------------------------------------------------------------
module dft_unit (
	input  wire logic [1:0]        cmd,
	input  wire logic [7:0]        req_type,
	input  wire logic [15:0]       period,
	input  wire logic [7:0]        ent_type,
	input  wire logic [15:0]       ent_count,
	input  wire logic              is_last,
	output dft_pkg::dft_step_t     step
);
	import dft_pkg::*;

	logic [15:0] dec_src;
	logic [15:0] dec;
	logic        ent_free;
	logic        ent_match;

	assign dec_src   = (cmd == CMD_ADD) ? period : ent_count;
	assign dec       = dec_src - 16'd1;
	assign ent_free  = (ent_type == FREE_TYPE);
	assign ent_match = (ent_type == req_type);

	always_comb begin
		step           = '0;
		step.wr_type   = ent_type;
		step.wr_count  = ent_count;
		step.status    = ST_OK;
		unique case (cmd)
			CMD_ADD: begin
				if (req_type == FREE_TYPE) begin
					step.done = 1'b1;
				end else if (ent_free) begin
					step.done     = 1'b1;
					step.wr_en    = 1'b1;
					step.wr_type  = req_type;
					step.wr_count = (period > 16'd1) ? dec : period;
					step.at_slot  = 1'b1;
				end else if (ent_match) begin
					step.done    = 1'b1;
					step.status  = ST_REGISTERED;
					step.at_slot = 1'b1;
					if (ent_count < period) begin
						step.wr_en    = 1'b1;
						step.wr_count = period;
					end
				end else if (is_last) begin
					step.done   = 1'b1;
					step.status = ST_FULL;
				end
			end
			CMD_TICK: begin
				step.done = is_last;
				if (!ent_free && (ent_count != 16'd0)) begin
					step.wr_en    = 1'b1;
					step.wr_count = dec;
					step.wr_type  = (ent_count == 16'd1) ? FREE_TYPE : ent_type;
				end
			end
			CMD_QUERY: begin
				if (ent_match) begin
					step.done      = 1'b1;
					step.remaining = ent_count;
				end else if (is_last) begin
					step.done = 1'b1;
				end
			end
			default: begin
				step.done = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: design/dft_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dft_ctrl: request sequencer
// Captures a request, walks the slots one per cycle through the shared
// unit, applies slot updates and loads the result register.
// ----------------------------------------------------------------------------
module dft_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [1:0]                command,
	input  wire logic [7:0]                flag_type,
	input  wire logic [15:0]               period,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic      [1:0]                status,
	output logic      [3:0]                slot,
	output logic      [15:0]               remaining,
	output logic      [1:0]                cmd,
	output logic      [7:0]                req_type,
	output logic      [15:0]               req_period,
	output logic      [dft_pkg::IDX_W-1:0] idx,
	output logic                           is_last,
	input  wire dft_pkg::dft_step_t        step,
	output dft_pkg::dft_wr_t               wr
);
	import dft_pkg::*;

	dft_state_t        state_q, state_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [1:0]        cmd_q;
	logic [7:0]        type_q;
	logic [15:0]       period_q;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [3:0]        slot_q;
	logic [15:0]       remaining_q;
	logic              accept;
	logic              load_out;
	logic              out_busy;
	logic [IDX_W+3:0]  idx_ext;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign out_busy = out_valid_q && out_stall;
	assign is_last  = (idx_q == IDX_W'(SLOTS - 1));
	assign idx_ext  = {4'b0000, idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= command;
			type_q   <= flag_type;
			period_q <= period;
		end
		if (load_out) begin
			status_q    <= step.status;
			slot_q      <= step.at_slot ? idx_ext[3:0] : 4'd0;
			remaining_q <= step.remaining;
		end
	end

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		load_out = 1'b0;
		wr.en    = 1'b0;
		wr.idx   = idx_q;
		wr.typ   = step.wr_type;
		wr.cnt   = step.wr_count;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_SCAN;
					idx_d   = '0;
				end
			end
			S_SCAN: begin
				if (step.done) begin
					if (!out_busy) begin
						load_out = 1'b1;
						wr.en    = step.wr_en;
						state_d  = S_IDLE;
					end
				end else begin
					wr.en = step.wr_en;
					idx_d = idx_q + IDX_W'(1);
				end
			end
		endcase
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot       = slot_q;
	assign remaining  = remaining_q;
	assign cmd        = cmd_q;
	assign req_type   = type_q;
	assign req_period = period_q;
	assign idx        = idx_q;

endmodule
`default_nettype wire

FILE: design/delay_flag_timer_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// delay_flag_timer_table_core: table of named delay flags
// Add, tick and query requests on a table of countdown slots.
// Usage:
//   Request channel: in_valid / in_stall with command, flag_type, period.
//   Result channel:  out_valid / out_stall with status, slot, remaining.
//   Each request gives exactly one result, in request order.
//   One request is worked on at a time; in_stall is high from the cycle
//   after a request is taken until its result is loaded.
//   The shared slot unit visits one slot per cycle: an add ends at the first
//   free or matching slot, a query at the first matching slot, a tick visits
//   all SLOTS slots. Every scan starts at slot 0; the result is loaded into
//   the result register as the scan ends.
//   The result register frees the scan from the receiver: a new request is
//   taken while a result waits. When the receiver stalls, the result holds
//   and the next scan holds at its last slot, without updating the table,
//   until the register frees.
//   Reset frees every slot, clears all counts and empties the result.
// ----------------------------------------------------------------------------
module delay_flag_timer_table_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [7:0]  flag_type,
	input  wire logic [15:0] period,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [1:0]  status,
	output logic      [3:0]  slot,
	output logic      [15:0] remaining
);
	import dft_pkg::*;

	logic [1:0]       cmd;
	logic [7:0]       req_type;
	logic [15:0]      req_period;
	logic [IDX_W-1:0] idx;
	logic             is_last;
	logic [7:0]       ent_type;
	logic [15:0]      ent_count;
	dft_step_t        step;
	dft_wr_t          wr;

	dft_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (idx),
		.rd_type  (ent_type),
		.rd_count (ent_count),
		.wr       (wr)
	);

	dft_unit u_unit (
		.cmd       (cmd),
		.req_type  (req_type),
		.period    (req_period),
		.ent_type  (ent_type),
		.ent_count (ent_count),
		.is_last   (is_last),
		.step      (step)
	);

	dft_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.flag_type  (flag_type),
		.period     (period),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.slot       (slot),
		.remaining  (remaining),
		.cmd        (cmd),
		.req_type   (req_type),
		.req_period (req_period),
		.idx        (idx),
		.is_last    (is_last),
		.step       (step),
		.wr         (wr)
	);

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken but sequencer not busy");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !wr.en)
		else $error("table written while idle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_REGISTERED || status == ST_FULL))
		else $error("bad status code");

	a_remaining_query_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && remaining != 16'd0 |-> status == ST_OK && slot == 4'd0)
		else $error("remaining count on a non-query result");
`endif

endmodule
`default_nettype wire
